// ===== rtl/vas_pkg.sv =====
// ----------------------------------------------------------------------------
// vas_pkg: shared types and constants of the letter block scrambler
// Key layout, register codes, GF(2^8) helpers and the control bundles that
// pass between the scrambler's modules.
// ----------------------------------------------------------------------------
package vas_pkg;

    localparam int KEY_LETTERS = 24;
    localparam int KEY_HALF    = KEY_LETTERS / 2;
    localparam int SHIFT_W     = 5;
    localparam int KEY_REG_W   = KEY_HALF * SHIFT_W;
    localparam int BLOCK_BYTES = 16;
    localparam int ADDR_W      = $clog2(BLOCK_BYTES);
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int POS_W       = 5;
    localparam int LEN_W       = 5;
    localparam int APB_DW      = 64;
    localparam int APB_AW      = 5;

    localparam logic [7:0] PAD_LETTER = 8'h41;
    localparam logic [7:0] UPPER_LAST = 8'h5A;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_FOLD  = 8'h20;
    localparam logic [7:0] GF_REDUCE  = 8'h1B;
    localparam int         ALPHABET   = 26;

    typedef enum logic [1:0] {
        REG_KEY_LOW  = 2'd0,
        REG_KEY_HIGH = 2'd1,
        REG_KEY_LEN  = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        COEF_TWO   = 2'd0,
        COEF_THREE = 2'd1,
        COEF_ONE_A = 2'd2,
        COEF_ONE_B = 2'd3
    } t_coef;

    typedef enum logic {
        S_IDLE,
        S_MAC
    } t_state;

    typedef struct packed {
        logic [KEY_REG_W-1:0] key_low;
        logic [KEY_REG_W-1:0] key_high;
        logic [LEN_W-1:0]     key_len;
    } t_key_cfg;

    typedef struct packed {
        logic             is_letter;
        logic [7:0]       letter;
        logic [POS_W-1:0] next_pos;
    } t_letter;

    typedef struct packed {
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [7:0]         wr_data;
        logic               blk_load;
        logic [COUNT_W-1:0] blk_count;
        logic               run;
        logic [1:0]         step;
        logic [ADDR_W-1:0]  out_idx;
    } t_mix_ctl;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
    endfunction

endpackage

// ===== rtl/vas_cfg.sv =====
// ----------------------------------------------------------------------------
// vas_cfg: configuration registers
// APB-style register file holding the key letters and the key length.
// ----------------------------------------------------------------------------
module vas_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [vas_pkg::APB_AW-1:0]    i_paddr,
    input  logic [vas_pkg::APB_DW-1:0]    i_pwdata,
    output logic [vas_pkg::APB_DW-1:0]    o_prdata,
    output vas_pkg::t_key_cfg             o_cfg
);

    logic [vas_pkg::KEY_REG_W-1:0] r_key_low;
    logic [vas_pkg::KEY_REG_W-1:0] r_key_high;
    logic [vas_pkg::LEN_W-1:0]     r_key_len;
    logic                          wr;
    vas_pkg::t_reg_idx             idx;

    assign wr  = i_psel & i_penable & i_pwrite;
    assign idx = vas_pkg::t_reg_idx'(i_paddr[vas_pkg::APB_AW-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= vas_pkg::LEN_W'(1);
        end else if (wr) begin
            unique case (idx)
                vas_pkg::REG_KEY_LOW:  r_key_low  <= i_pwdata[vas_pkg::KEY_REG_W-1:0];
                vas_pkg::REG_KEY_HIGH: r_key_high <= i_pwdata[vas_pkg::KEY_REG_W-1:0];
                vas_pkg::REG_KEY_LEN:  r_key_len  <= i_pwdata[vas_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            vas_pkg::REG_KEY_LOW:
                o_prdata = vas_pkg::APB_DW'(r_key_low);
            vas_pkg::REG_KEY_HIGH:
                o_prdata = vas_pkg::APB_DW'(r_key_high);
            vas_pkg::REG_KEY_LEN:
                o_prdata = vas_pkg::APB_DW'(r_key_len);
            default:
                o_prdata = '0;
        endcase
    end

    assign o_cfg = '{key_low: r_key_low, key_high: r_key_high, key_len: r_key_len};

endmodule

// ===== rtl/vas_letter.sv =====
// ----------------------------------------------------------------------------
// vas_letter: letter filter and Vigenere shift
// Folds case, drops non-letters and shifts a letter by the current key
// letter modulo 26.
// ----------------------------------------------------------------------------
module vas_letter (
    input  logic [7:0]                i_byte,
    input  logic [vas_pkg::POS_W-1:0] i_key_pos,
    input  vas_pkg::t_key_cfg         i_cfg,
    output vas_pkg::t_letter          o_letter
);

    logic [vas_pkg::SHIFT_W-1:0] keys [vas_pkg::KEY_LETTERS];
    logic [vas_pkg::LEN_W-1:0]   eff_len;
    logic [vas_pkg::POS_W-1:0]   pos_used;
    logic [7:0]                  folded;
    logic                        is_letter;
    logic [5:0]                  sum;
    logic [4:0]                  reduced;

    always_comb begin
        for (int i = 0; i < vas_pkg::KEY_HALF; i++) begin
            keys[i] = i_cfg.key_low[i*vas_pkg::SHIFT_W +: vas_pkg::SHIFT_W];
            keys[i+vas_pkg::KEY_HALF] =
                i_cfg.key_high[i*vas_pkg::SHIFT_W +: vas_pkg::SHIFT_W];
        end
    end

    // Clamp the key length to 1..KEY_LETTERS
    always_comb begin
        if (i_cfg.key_len == '0) begin
            eff_len = vas_pkg::LEN_W'(1);
        end else if (i_cfg.key_len > vas_pkg::LEN_W'(vas_pkg::KEY_LETTERS)) begin
            eff_len = vas_pkg::LEN_W'(vas_pkg::KEY_LETTERS);
        end else begin
            eff_len = i_cfg.key_len;
        end
    end

    assign pos_used = (i_key_pos >= vas_pkg::POS_W'(eff_len)) ? '0 : i_key_pos;

    always_comb begin
        if (i_byte >= vas_pkg::LOWER_A && i_byte <= vas_pkg::LOWER_Z) begin
            folded = i_byte - vas_pkg::CASE_FOLD;
        end else begin
            folded = i_byte;
        end
    end

    assign is_letter = (folded >= vas_pkg::PAD_LETTER) && (folded <= vas_pkg::UPPER_LAST);
    assign sum = 6'(folded - vas_pkg::PAD_LETTER) + 6'(keys[pos_used]);

    // Sum stays below three alphabets, so two compare-and-subtract steps reduce it
    always_comb begin
        if (sum >= 6'(2 * vas_pkg::ALPHABET)) begin
            reduced = 5'(sum - 6'(2 * vas_pkg::ALPHABET));
        end else if (sum >= 6'(vas_pkg::ALPHABET)) begin
            reduced = 5'(sum - 6'(vas_pkg::ALPHABET));
        end else begin
            reduced = sum[4:0];
        end
    end

    assign o_letter = '{
        is_letter: is_letter,
        letter:    8'(reduced) + vas_pkg::PAD_LETTER,
        next_pos:  pos_used + vas_pkg::POS_W'(1)
    };

endmodule

// ===== rtl/vas_mix.sv =====
// ----------------------------------------------------------------------------
// vas_mix: block store and shared GF(2^8) multiply-accumulate unit
// Holds the 4x4 letter block and builds one mixed byte per four steps:
// row rotate, parity mark and one MixColumns term per step.
// ----------------------------------------------------------------------------
module vas_mix (
    input  logic              i_clk,
    input  vas_pkg::t_mix_ctl i_ctl,
    output logic [7:0]        o_mixed
);

    logic [7:0]                  r_store [vas_pkg::BLOCK_BYTES];
    logic [vas_pkg::COUNT_W-1:0] r_blk_count;
    logic [7:0]                  r_acc;

    logic [1:0]                  row;
    logic [1:0]                  col;
    logic [vas_pkg::ADDR_W-1:0]  rd_addr;
    logic [7:0]                  raw;
    logic [7:0]                  marked;
    logic [7:0]                  term;
    vas_pkg::t_coef              coef;

    assign row = i_ctl.out_idx[3:2];
    assign col = i_ctl.out_idx[1:0];

    // Row rotate: entry (step, col) of the rotated block sits at column col+step
    assign rd_addr = {i_ctl.step, 2'(col + i_ctl.step)};

    // Entries past the block's letter count are padding
    always_comb begin
        raw = ({1'b0, rd_addr} >= r_blk_count) ? vas_pkg::PAD_LETTER : r_store[rd_addr];
    end

    assign marked = {raw[7] | (^raw), raw[6:0]};
    assign coef   = vas_pkg::t_coef'(2'(i_ctl.step - row));

    always_comb begin
        case (coef)
            vas_pkg::COEF_TWO:   term = vas_pkg::xtime(marked);
            vas_pkg::COEF_THREE: term = vas_pkg::xtime(marked) ^ marked;
            default:             term = marked;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_store[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        if (i_ctl.blk_load) begin
            r_blk_count <= i_ctl.blk_count;
        end
        if (i_ctl.run) begin
            r_acc <= (i_ctl.step == 2'd0) ? term : (r_acc ^ term);
        end
    end

    assign o_mixed = r_acc ^ term;

endmodule

// ===== rtl/vigenere_aes_block_scrambler.sv =====
// ----------------------------------------------------------------------------
// vigenere_aes_block_scrambler: letter block scrambler top level
// The item that completes or ends a block starts the mixing; each mixed byte
// is registered at the output once its steps are done. Throughput: one item
// per cycle while a block fills; the input then waits while the single
// GF(2^8) multiply-accumulate unit builds every byte, output stalls included.
// Reset is synchronous, active low: key registers, fill count, key position
// and control clear; the store does not.
// ----------------------------------------------------------------------------
module vigenere_aes_block_scrambler (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [7:0]                 i_s_tdata,  // [7:0] text_byte
    input  logic                       i_s_tlast,  // end_of_message
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [7:0]                 o_m_tdata,  // [7:0] cipher_byte
    output logic                       o_m_tlast,  // end of block
    output logic                       o_m_tuser,  // [0] message_end
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [vas_pkg::APB_AW-1:0] paddr,
    input  logic [vas_pkg::APB_DW-1:0] pwdata,
    output logic [vas_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    vas_pkg::t_key_cfg           cfg;
    vas_pkg::t_letter            letter;
    vas_pkg::t_mix_ctl           mix_ctl;
    logic [7:0]                  mixed;

    vas_pkg::t_state             r_state;
    vas_pkg::t_state             n_state;
    logic [vas_pkg::ADDR_W-1:0]  r_fill;
    logic [vas_pkg::POS_W-1:0]   r_key_pos;
    logic [1:0]                  r_step;
    logic [vas_pkg::ADDR_W-1:0]  r_out_idx;
    logic                        r_msg_last;
    logic                        r_out_valid;
    logic [7:0]                  r_out_data;
    logic                        r_out_last;
    logic                        r_out_user;

    logic                        in_acc;
    logic [vas_pkg::COUNT_W-1:0] fill_sum;
    logic                        trigger;
    logic                        out_free;
    logic                        advance;
    logic                        load;
    logic                        idx_last;

    assign pready = 1'b1;

    vas_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    vas_letter u_letter (
        .i_byte    (i_s_tdata),
        .i_key_pos (r_key_pos),
        .i_cfg     (cfg),
        .o_letter  (letter)
    );

    vas_mix u_mix (
        .i_clk   (i_clk),
        .i_ctl   (mix_ctl),
        .o_mixed (mixed)
    );

    assign in_acc   = i_s_tvalid & o_s_tready;
    assign fill_sum = {1'b0, r_fill} + vas_pkg::COUNT_W'(letter.is_letter);
    assign trigger  = (fill_sum == vas_pkg::COUNT_W'(vas_pkg::BLOCK_BYTES))
                    || (i_s_tlast && fill_sum != '0);
    assign out_free = !r_out_valid || i_m_tready;
    assign idx_last = (r_out_idx == vas_pkg::ADDR_W'(vas_pkg::BLOCK_BYTES - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vas_pkg::S_IDLE: begin
                if (in_acc && trigger) begin
                    n_state = vas_pkg::S_MAC;
                end
            end
            vas_pkg::S_MAC: begin
                if (load && idx_last) begin
                    n_state = vas_pkg::S_IDLE;
                end
            end
            default: n_state = vas_pkg::S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_s_tready = 1'b0;
        advance    = 1'b0;
        load       = 1'b0;
        unique case (r_state)
            vas_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
            end
            vas_pkg::S_MAC: begin
                // Hold on the last step until the output register frees up
                advance = (r_step != 2'd3) || out_free;
                load    = (r_step == 2'd3) && out_free;
            end
            default: ;
        endcase
    end

    assign mix_ctl = '{
        wr_en:     in_acc && letter.is_letter,
        wr_addr:   r_fill,
        wr_data:   letter.letter,
        blk_load:  in_acc && trigger,
        blk_count: fill_sum,
        run:       advance,
        step:      r_step,
        out_idx:   r_out_idx
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vas_pkg::S_IDLE;
            r_fill      <= '0;
            r_key_pos   <= '0;
            r_step      <= '0;
            r_out_idx   <= '0;
            r_msg_last  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_fill <= trigger ? '0 : fill_sum[vas_pkg::ADDR_W-1:0];
                if (i_s_tlast) begin
                    r_key_pos <= '0;
                end else if (letter.is_letter) begin
                    r_key_pos <= letter.next_pos;
                end
                if (trigger) begin
                    r_msg_last <= i_s_tlast;
                end
            end
            if (advance) begin
                r_step <= r_step + 2'd1;
            end
            if (load) begin
                r_out_idx <= r_out_idx + vas_pkg::ADDR_W'(1);
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= mixed;
            r_out_last <= idx_last;
            r_out_user <= idx_last && r_msg_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

    // A block starts with the step and byte counters at zero
    a_block_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vas_pkg::S_IDLE && n_state == vas_pkg::S_MAC)
        |=> (r_step == 2'd0 && r_out_idx == '0))
        else $error("block started with counters not at zero");

    // Message end only ever rides on the closing byte of a block
    a_msg_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("message end without block end");

    // Key position never runs more than one past the last key letter
    a_key_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_key_pos <= vas_pkg::POS_W'(vas_pkg::KEY_LETTERS)))
        else $error("key position out of range");

    // No new byte is loaded over one that has not been taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_out_valid) |-> i_m_tready)
        else $error("output byte overwritten");

endmodule

// ===== verif/tb_vigenere_aes_block_scrambler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vigenere_aes_block_scrambler: self-checking bench for the block scrambler
// Streams message bytes in, programs key settings over APB between phases,
// predicts every cipher byte with a behavioural block model and compares it
// field by field as the bytes leave, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_vigenere_aes_block_scrambler;

    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 80;
    localparam int REG_SPARE    = 3;

    typedef struct packed {
        logic [7:0] cipher;
        logic       blk_end;
        logic       msg_end;
    } t_cipher;

    // Behavioural model of the scrambler plus the queue of cipher bytes due
    class cipher_board;
        logic [vas_pkg::KEY_REG_W-1:0] key_lo;
        logic [vas_pkg::KEY_REG_W-1:0] key_hi;
        logic [vas_pkg::LEN_W-1:0]     key_len;
        logic [7:0]                    letters [vas_pkg::BLOCK_BYTES];
        int unsigned                   fill;
        int unsigned                   pos;
        t_cipher                       cipher_due [$];
        int                            errors;
        int                            bytes_seen;
        int                            blocks_seen;

        function new();
            key_lo      = '0;
            key_hi      = '0;
            key_len     = 5'd1;
            fill        = 0;
            pos         = 0;
            errors      = 0;
            bytes_seen  = 0;
            blocks_seen = 0;
        endfunction

        task flag(input string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        function void write_reg(input int idx, input logic [vas_pkg::APB_DW-1:0] value);
            case (idx)
                vas_pkg::REG_KEY_LOW:  key_lo  = value[vas_pkg::KEY_REG_W-1:0];
                vas_pkg::REG_KEY_HIGH: key_hi  = value[vas_pkg::KEY_REG_W-1:0];
                vas_pkg::REG_KEY_LEN:  key_len = value[vas_pkg::LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned shift_at(input int unsigned p);
            if (p < vas_pkg::KEY_HALF)
                return 32'(key_lo[vas_pkg::SHIFT_W*p +: vas_pkg::SHIFT_W]);
            return 32'(key_hi[vas_pkg::SHIFT_W*(p-vas_pkg::KEY_HALF) +: vas_pkg::SHIFT_W]);
        endfunction

        function logic [7:0] gf_double(input logic [7:0] b);
            return {b[6:0], 1'b0} ^ (b[7] ? vas_pkg::GF_REDUCE : 8'h00);
        endfunction

        function logic [7:0] mark_parity(input logic [7:0] b);
            return (^b) ? (b | 8'h80) : b;
        endfunction

        function void emit_block(input bit last);
            logic [7:0] rot [vas_pkg::BLOCK_BYTES];
            logic [7:0] mixed [vas_pkg::BLOCK_BYTES];
            logic [7:0] a0, a1, a2, a3;
            t_cipher    c;
            for (int r = 0; r < 4; r++)
                for (int k = 0; k < 4; k++)
                    rot[r*4+k] = mark_parity(letters[r*4 + ((k + r) % 4)]);
            for (int k = 0; k < 4; k++) begin
                a0 = rot[k];
                a1 = rot[4+k];
                a2 = rot[8+k];
                a3 = rot[12+k];
                mixed[k]    = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
                mixed[4+k]  = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
                mixed[8+k]  = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
                mixed[12+k] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
            end
            for (int i = 0; i < vas_pkg::BLOCK_BYTES; i++) begin
                c.cipher  = mixed[i];
                c.blk_end = (i == vas_pkg::BLOCK_BYTES - 1);
                c.msg_end = (i == vas_pkg::BLOCK_BYTES - 1) && last;
                cipher_due.push_back(c);
            end
        endfunction

        function void take_text(input logic [7:0] text, input logic eom);
            logic [7:0]  ch;
            int unsigned len;
            int unsigned v;
            ch  = text;
            len = (key_len == 0) ? 1 :
                  ((key_len > vas_pkg::KEY_LETTERS) ? vas_pkg::KEY_LETTERS : key_len);
            if (ch >= vas_pkg::LOWER_A && ch <= vas_pkg::LOWER_Z) ch = ch - vas_pkg::CASE_FOLD;
            if (ch >= vas_pkg::PAD_LETTER && ch <= vas_pkg::UPPER_LAST) begin
                // wrap a stale position left over from a longer key
                if (pos >= len) pos = 0;
                v = ((ch - vas_pkg::PAD_LETTER) + shift_at(pos)) % vas_pkg::ALPHABET;
                pos = (pos + 1) & 31;
                letters[fill] = 8'(v) + vas_pkg::PAD_LETTER;
                fill++;
                if (fill == vas_pkg::BLOCK_BYTES) begin
                    fill = 0;
                    emit_block(eom);
                end
            end
            if (eom) begin
                if (fill != 0) begin
                    for (int i = fill; i < vas_pkg::BLOCK_BYTES; i++)
                        letters[i] = vas_pkg::PAD_LETTER;
                    fill = 0;
                    emit_block(1'b1);
                end
                pos = 0;
            end
        endfunction

        task check_cipher(input logic [7:0] data, input logic blk_end, input logic msg_end);
            t_cipher want;
            bytes_seen++;
            if (cipher_due.size() == 0) begin
                flag($sformatf("unexpected cipher byte %02h", data));
            end else begin
                want = cipher_due.pop_front();
                if (data !== want.cipher)
                    flag($sformatf("cipher_byte %02h, want %02h", data, want.cipher));
                if (blk_end !== want.blk_end)
                    flag($sformatf("end of block %b, want %b", blk_end, want.blk_end));
                if (msg_end !== want.msg_end)
                    flag($sformatf("message_end %b, want %b", msg_end, want.msg_end));
                if (want.blk_end) blocks_seen++;
            end
        endtask
    endclass

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_s_tvalid = 1'b0;
    logic                       o_s_tready;
    logic [7:0]                 i_s_tdata  = '0;  // [7:0] text_byte
    logic                       i_s_tlast  = 1'b0; // end_of_message
    logic                       o_m_tvalid;
    logic                       i_m_tready = 1'b0;
    logic [7:0]                 o_m_tdata;        // [7:0] cipher_byte
    logic                       o_m_tlast;        // end of block
    logic                       o_m_tuser;        // [0] message_end
    logic                       psel       = 1'b0;
    logic                       penable    = 1'b0;
    logic                       pwrite     = 1'b0;
    logic [vas_pkg::APB_AW-1:0] paddr      = '0;
    logic [vas_pkg::APB_DW-1:0] pwdata     = '0;
    logic [vas_pkg::APB_DW-1:0] prdata;
    logic                       pready;

    cipher_board board = new();
    bit          quiet = 1'b0;
    int          text_items = 0;
    int          key_settings = 0;

    vigenere_aes_block_scrambler uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic cfg_write(input int idx, input logic [vas_pkg::APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= vas_pkg::APB_AW'(idx * 8);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_key(input logic [vas_pkg::KEY_REG_W-1:0] lo,
                             input logic [vas_pkg::KEY_REG_W-1:0] hi,
                             input logic [vas_pkg::LEN_W-1:0] len);
        cfg_write(vas_pkg::REG_KEY_LOW, vas_pkg::APB_DW'(lo));
        cfg_write(vas_pkg::REG_KEY_HIGH, vas_pkg::APB_DW'(hi));
        cfg_write(vas_pkg::REG_KEY_LEN, vas_pkg::APB_DW'(len));
        key_settings++;
    endtask

    function automatic logic [vas_pkg::KEY_REG_W-1:0] rand_key(input int unsigned top);
        logic [vas_pkg::KEY_REG_W-1:0] k;
        for (int i = 0; i < vas_pkg::KEY_HALF; i++)
            k[vas_pkg::SHIFT_W*i +: vas_pkg::SHIFT_W] =
                vas_pkg::SHIFT_W'($urandom_range(0, top));
        return k;
    endfunction

    function automatic logic [7:0] pick_letter();
        return ($urandom_range(0, 1) ? vas_pkg::LOWER_A : vas_pkg::PAD_LETTER)
               + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_text();
        return ($urandom_range(0, 9) < 7) ? pick_letter() : 8'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic [7:0] text, input logic eom);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= text;
        i_s_tlast  <= eom;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.take_text(text, eom);
        text_items++;
    endtask

    task automatic send_message(input int n);
        for (int i = 0; i < n; i++) send_item(pick_text(), i == n - 1);
    endtask

    // drop the stream and let the block finish before the next key change
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (board.cipher_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : sink
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) board.check_cipher(o_m_tdata, o_m_tlast, o_m_tuser);
            if (hold > 0) hold--;
            else if (!quiet && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 16);
            i_m_tready <= (hold == 0);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (psel && penable && pready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [8:0] directed [$];
        directed = {9'h000, 9'h0FF, 9'h040, 9'h05B, 9'h060, 9'h07B, 9'h080, 9'h0E1,
                    9'h061, 9'h07A, 9'h041, 9'h05A, 9'h06D, 9'h051, 9'h062, 9'h079,
                    9'h043, 9'h078, 9'h04B, 9'h06F, 9'h054, 9'h070, 9'h064, 9'h153,
                    9'h120, 9'h15A};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // shifts above 25 across the low key half, zero key length; full block
        // on message end, empty remainder, then a one-letter message
        apply_key({vas_pkg::KEY_REG_W{1'b1}}, '0, '0);
        foreach (directed[i]) send_item(directed[i][7:0], directed[i][8]);
        settle();

        // oversized key length saturates; run past the key's wrap point
        apply_key(rand_key(31), {vas_pkg::KEY_REG_W{1'b1}}, 5'd31);
        repeat (28) send_item(pick_letter(), 1'b0);
        settle();

        // shorten the key mid-message and poke an unmapped register
        cfg_write(vas_pkg::REG_KEY_LEN, vas_pkg::APB_DW'(3));
        cfg_write(REG_SPARE, {$urandom, $urandom});
        key_settings++;
        send_message(12);
        settle();

        for (int s = 0; s < 3; s++) begin
            apply_key(rand_key(25), rand_key(25),
                      (s == 0) ? 5'd1 : ((s == 1) ? 5'd24 : 5'($urandom_range(2, 23))));
            repeat (2) send_message($urandom_range(1, 8));
            settle();
        end

        // last stretch runs flat out on both sides
        quiet = 1'b1;
        apply_key('0, '0, 5'd24);
        send_message(10);
        send_message(14);
        settle();

        if (board.cipher_due.size() != 0)
            board.flag($sformatf("%0d cipher bytes never arrived", board.cipher_due.size()));
        $display("Covered %0d text items under %0d key settings", text_items, key_settings);
        $display("Checked %0d cipher bytes in %0d blocks, %0d errors",
                 board.bytes_seen, board.blocks_seen, board.errors);
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/vas_pkg.sv
rtl/vas_cfg.sv
rtl/vas_letter.sv
rtl/vas_mix.sv
rtl/vigenere_aes_block_scrambler.sv
verif/tb_vigenere_aes_block_scrambler.sv
